### rtl/nhbl_pkg.sv
// shared types and constants for the nibble handshake byte link
// no dependencies

package nhbl_pkg;

    localparam int unsigned SPIN_W = 16;
    localparam logic [SPIN_W-1:0] SPIN_LIMIT_RESET = 16'd1000;

    localparam logic FUNC_START  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic [1:0] BURST_HI_STROBE = 2'd0;
    localparam logic [1:0] BURST_HI_DROP   = 2'd1;
    localparam logic [1:0] BURST_LO_STROBE = 2'd2;
    localparam logic [1:0] BURST_LO_DROP   = 2'd3;

    typedef struct packed {
        logic [3:0] drive_nibble;
        logic       drive_strobe;
        logic       byte_done;
        logic [7:0] recv_byte;
        logic       timeout_error;
        logic       busy_res;
    } nhbl_result_t;

endpackage

### rtl/nibble_handshake_byte_link.sv
// top level of the nibble handshake byte link: input handshake, core, result register
// depends on nhbl_pkg and nhbl_core
//
//  channel   prefix  direction  carries
//  input     s_      in         start command or one port sample
//  result    m_      out        drive levels and byte status
//  config    cfg_    in         spin limit, always ready
//
// one transaction per cycle while s_ready is high; a full-exchange transaction gives at most one result,
// a write-only start gives four results from the result register
// a sample while idle gives no result
// synchronous active-low reset; spin limit returns to 1000
// input is taken while the result register is empty or its last result leaves

module nibble_handshake_byte_link (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_func,
    input  logic [7:0] s_send_byte,
    input  logic       s_write_only,
    input  logic [3:0] s_port_nibble,
    input  logic       s_port_ack,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_drive_nibble,
    output logic       m_drive_strobe,
    output logic       m_byte_done,
    output logic [7:0] m_recv_byte,
    output logic       m_timeout_error,
    output logic       m_busy_res,
    output logic       m_last_of_run,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [15:0] cfg_wdata
);
    import nhbl_pkg::*;

    logic         item_accept;
    nhbl_result_t core_res;
    logic         core_res_valid;
    logic         core_res_burst;

    logic         out_valid_reg;
    nhbl_result_t res_reg;
    logic         burst_reg;
    logic [1:0]   step_reg;
    logic [7:0]   burst_byte_reg;

    nhbl_result_t out_res;
    logic         out_last;
    logic         out_take;

    assign cfg_ready   = 1'b1;
    assign out_last    = !burst_reg || (step_reg == BURST_LO_DROP);
    assign out_take    = out_valid_reg && m_ready;
    assign s_ready     = !out_valid_reg || (m_ready && out_last);
    assign item_accept = s_valid && s_ready;

    nhbl_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_accept (item_accept),
        .func        (s_func),
        .send_byte   (s_send_byte),
        .write_only  (s_write_only),
        .port_nibble (s_port_nibble),
        .port_ack    (s_port_ack),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_wdata),
        .res         (core_res),
        .res_valid   (core_res_valid),
        .res_burst   (core_res_burst)
    );

    always_comb begin
        out_res = res_reg;
        if (burst_reg) begin
            out_res = '0;
            unique case (step_reg)
                BURST_HI_STROBE: begin
                    out_res.drive_nibble = burst_byte_reg[7:4];
                    out_res.drive_strobe = 1'b1;
                end
                BURST_HI_DROP: begin
                end
                BURST_LO_STROBE: begin
                    out_res.drive_nibble = burst_byte_reg[3:0];
                    out_res.drive_strobe = 1'b1;
                end
                BURST_LO_DROP: begin
                    out_res.byte_done = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            burst_reg     <= 1'b0;
            step_reg      <= BURST_HI_STROBE;
        end else begin
            if (item_accept && core_res_valid) begin
                out_valid_reg <= 1'b1;
                burst_reg     <= core_res_burst;
                step_reg      <= BURST_HI_STROBE;
            end else if (out_take) begin
                if (out_last) begin
                    out_valid_reg <= 1'b0;
                end else begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_accept && core_res_valid) begin
            res_reg        <= core_res;
            burst_byte_reg <= s_send_byte;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_drive_nibble  = out_res.drive_nibble;
    assign m_drive_strobe  = out_res.drive_strobe;
    assign m_byte_done     = out_res.byte_done;
    assign m_recv_byte     = out_res.recv_byte;
    assign m_timeout_error = out_res.timeout_error;
    assign m_busy_res      = out_res.busy_res;
    assign m_last_of_run   = out_last;

endmodule

### rtl/nhbl_core.sv
// handshake state, spin counter and result formation for one transaction
// depends on nhbl_pkg

module nhbl_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  item_accept,
    input  logic                  func,
    input  logic [7:0]            send_byte,
    input  logic                  write_only,
    input  logic [3:0]            port_nibble,
    input  logic                  port_ack,
    input  logic                  cfg_we,
    input  logic [15:0]           cfg_data,
    output nhbl_pkg::nhbl_result_t res,
    output logic                  res_valid,
    output logic                  res_burst
);
    import nhbl_pkg::*;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_WAIT_HI = 2'd1;
    localparam logic [1:0] PH_WAIT_LO = 2'd2;

    logic [1:0]        phase_reg, phase_next;
    logic              low_turn_reg, low_turn_next;
    logic [SPIN_W:0]   spin_count_reg, spin_count_next;
    logic [7:0]        recv_accum_reg, recv_accum_next;
    logic [7:0]        send_latch_reg, send_latch_next;
    logic [SPIN_W-1:0] spin_limit_reg;

    logic [SPIN_W:0]   spin_inc;
    logic              spin_over;
    logic [3:0]        turn_nibble;

    assign spin_inc    = spin_count_reg + 1'b1;
    assign spin_over   = spin_inc > {1'b0, spin_limit_reg};
    assign turn_nibble = low_turn_reg ? send_latch_reg[3:0] : send_latch_reg[7:4];

    always_comb begin
        phase_next      = phase_reg;
        low_turn_next   = low_turn_reg;
        spin_count_next = spin_count_reg;
        recv_accum_next = recv_accum_reg;
        send_latch_next = send_latch_reg;
        res             = '0;
        res_valid       = 1'b0;
        res_burst       = 1'b0;
        if (item_accept) begin
            if (func == FUNC_START) begin
                send_latch_next = send_byte;
                low_turn_next   = 1'b0;
                spin_count_next = '0;
                recv_accum_next = '0;
                res_valid       = 1'b1;
                if (write_only) begin
                    phase_next = PH_IDLE;
                    res_burst  = 1'b1;
                end else begin
                    phase_next       = PH_WAIT_HI;
                    res.drive_nibble = send_byte[7:4];
                    res.drive_strobe = 1'b1;
                    res.busy_res     = 1'b1;
                end
            end else begin
                unique case (phase_reg)
                    PH_WAIT_HI: begin
                        res_valid = 1'b1;
                        if (port_ack) begin
                            recv_accum_next = {recv_accum_reg[3:0], port_nibble};
                            phase_next      = PH_WAIT_LO;
                            spin_count_next = '0;
                            res.busy_res    = 1'b1;
                        end else begin
                            spin_count_next  = spin_inc;
                            res.drive_nibble = turn_nibble;
                            res.drive_strobe = 1'b1;
                            if (spin_over) begin
                                phase_next        = PH_IDLE;
                                res.byte_done     = 1'b1;
                                res.timeout_error = 1'b1;
                            end else begin
                                res.busy_res = 1'b1;
                            end
                        end
                    end
                    PH_WAIT_LO: begin
                        res_valid = 1'b1;
                        if (!port_ack) begin
                            spin_count_next = '0;
                            if (!low_turn_reg) begin
                                low_turn_next    = 1'b1;
                                phase_next       = PH_WAIT_HI;
                                res.drive_nibble = send_latch_reg[3:0];
                                res.drive_strobe = 1'b1;
                                res.busy_res     = 1'b1;
                            end else begin
                                phase_next    = PH_IDLE;
                                res.byte_done = 1'b1;
                                res.recv_byte = recv_accum_reg;
                            end
                        end else begin
                            spin_count_next = spin_inc;
                            if (spin_over) begin
                                phase_next        = PH_IDLE;
                                res.byte_done     = 1'b1;
                                res.timeout_error = 1'b1;
                            end else begin
                                res.busy_res = 1'b1;
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            low_turn_reg   <= 1'b0;
            spin_count_reg <= '0;
            recv_accum_reg <= '0;
            send_latch_reg <= '0;
            spin_limit_reg <= SPIN_LIMIT_RESET;
        end else begin
            phase_reg      <= phase_next;
            low_turn_reg   <= low_turn_next;
            spin_count_reg <= spin_count_next;
            recv_accum_reg <= recv_accum_next;
            send_latch_reg <= send_latch_next;
            if (cfg_we) begin
                spin_limit_reg <= cfg_data;
            end
        end
    end

endmodule

### rtl/nhbl_checker.sv
// port-level checks for the nibble handshake byte link, bound to the top level
// no dependencies

module nhbl_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [3:0] m_drive_nibble,
    input logic       m_drive_strobe,
    input logic       m_byte_done,
    input logic [7:0] m_recv_byte,
    input logic       m_timeout_error,
    input logic       m_busy_res,
    input logic       m_last_of_run
);

    // stalled result transaction stays valid with drive nibble, strobe and last flag held
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drive_nibble)
            && $stable(m_drive_strobe) && $stable(m_last_of_run))
        else $error("stalled result changed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_drive_strobe |-> m_drive_nibble == 4'd0)
        else $error("nibble driven with strobe low");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_recv_byte != 8'd0 |-> m_byte_done && !m_timeout_error)
        else $error("received byte outside a successful finish");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_done |-> !m_busy_res && m_last_of_run)
        else $error("finished byte still busy or not last");

endmodule

bind nibble_handshake_byte_link nhbl_checker u_nhbl_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_drive_nibble  (m_drive_nibble),
    .m_drive_strobe  (m_drive_strobe),
    .m_byte_done     (m_byte_done),
    .m_recv_byte     (m_recv_byte),
    .m_timeout_error (m_timeout_error),
    .m_busy_res      (m_busy_res),
    .m_last_of_run   (m_last_of_run)
);
